/* hdl/bcba_pkg.sv */
// shared types, codes and default sizes for the block chained bump allocator
`timescale 1ns / 1ps
`default_nettype none
package bcba_pkg;

  // default pool geometry
  localparam int NUM_BLOCKS_DEF  = 32;
  localparam int BLOCK_BYTES_DEF = 4096;

  // allocation granule
  localparam int ALIGN_BYTES = 16;

  // field widths of the transactions
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int BLKIDX_W = 5;
  localparam int OFFSET_W = 12;
  localparam int ADDR_W   = 17;

  // padded request size, one bit wider than the size field
  localparam int PAD_W = SIZE_W + 1;

  localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(ALIGN_BYTES - 1);

  // command codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_BLOCKS = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RELEASED  = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] size;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLKIDX_W-1:0] block_index;
    logic [OFFSET_W-1:0] offset;
    logic [ADDR_W-1:0]   address;
  } out_item_t;

endpackage
`default_nettype wire

/* hdl/bcba_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/block_chained_bump_allocator.sv */
// top level of the block chained bump allocator
`timescale 1ns / 1ps
`default_nettype none
// Scratch allocator over NUM_BLOCKS equal blocks of BLOCK_BYTES bytes. An
// allocate transaction pads its size to (size | 15) + 1 and bumps the fill
// position of the current block; when it does not fit, a block is popped from
// the free list, chained in front of the current one and the allocation lands
// at offset 0. A release transaction hands the whole chain back to the free
// list through the kept tail pointer and restarts in the chain head. The
// free list and chain links live in one synchronous next-link ram with
// separate read and write ports and a registered read. An allocation that
// fits, a too-large or out-of-blocks answer and a release of a one-block
// chain are answered in ST_EXEC; an allocation that opens a new block passes
// ST_RD (link read); a release of a longer chain passes ST_RD and ST_WR2
// (link read and two link writes). Stalls on out_ready hold the state that
// loads the result. After reset a pass over all NUM_BLOCKS entries initializes
// the ram while in_ready stays low. Results are held in an output register,
// so a waiting result does not keep the next transaction from being accepted.
module block_chained_bump_allocator #(
  parameter int NUM_BLOCKS  = bcba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = bcba_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bcba_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bcba_pkg::out_item_t      out_data
);

  import bcba_pkg::*;

  // block index, link (with null) and fill position widths
  localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LW = $clog2(NUM_BLOCKS + 1);
  localparam int FW = $clog2(BLOCK_BYTES + 1);
  localparam int CW = PAD_W + 1;

  localparam logic [LW-1:0] LINK_NULL = LW'(NUM_BLOCKS);

  // sequencer states
  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WR2  = 3'd4;

  logic [2:0]    state_r,    state_nxt;
  logic [BW-1:0] init_cnt_r, init_cnt_nxt;
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [BW-1:0] cur_blk_r,  cur_blk_nxt;
  logic [BW-1:0] tail_r,     tail_nxt;
  logic [FW-1:0] fill_r,     fill_nxt;
  in_item_t      req_r,      req_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r,      out_nxt;

  // link ram port signals
  logic          ram_we;
  logic [BW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic          ram_re;
  logic [BW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata;

  // request decode
  logic [PAD_W-1:0] padded;
  logic             too_large;
  logic             fits;
  logic             fh_valid;
  logic [LW-1:0]    rd_link;
  logic             slot_free;

  // result loading
  logic                res_load;
  logic [STATUS_W-1:0] res_status;
  logic [BW-1:0]       res_blk;
  logic [FW-1:0]       res_off;
  logic [31:0]         res_blk32;
  logic [31:0]         res_off32;
  logic [31:0]         res_addr32;

  bcba_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // size padded to the next granule, always 1 to 16 bytes more than asked
  assign padded    = PAD_W'(req_r.size | ALIGN_MASK) + PAD_W'(1);
  assign too_large = CW'(padded) > CW'(BLOCK_BYTES);
  assign fits      = (CW'(padded) + CW'(fill_r)) <= CW'(BLOCK_BYTES);
  assign fh_valid  = free_head_r < LINK_NULL;
  // a link at or above NUM_BLOCKS means end of list
  assign rd_link   = (ram_rdata < LINK_NULL) ? ram_rdata : LINK_NULL;

  // output register can take a result this cycle
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // address is block times block size plus offset, cut to the field width
  assign res_blk32  = 32'(res_blk);
  assign res_off32  = 32'(res_off);
  assign res_addr32 = res_blk32 * 32'(BLOCK_BYTES) + res_off32;

  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    free_head_nxt = free_head_r;
    cur_blk_nxt   = cur_blk_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    res_load      = 1'b0;
    res_status    = STAT_OK;
    res_blk       = '0;
    res_off       = '0;

    unique case (state_r)
      ST_INIT: begin
        // block i links to i+1; the last one gets NUM_BLOCKS, the null code
        ram_we    = 1'b1;
        ram_waddr = init_cnt_r;
        ram_wdata = LW'(init_cnt_r) + LW'(1);
        if (init_cnt_r == BW'(NUM_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          init_cnt_nxt = init_cnt_r + BW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (req_r.cmd == CMD_RELEASE) begin
          if (tail_r == cur_blk_r) begin
            // one-block chain: it goes back and comes straight out again
            if (slot_free) begin
              fill_nxt   = '0;
              res_load   = 1'b1;
              res_status = STAT_RELEASED;
              res_blk    = cur_blk_r;
              state_nxt  = ST_IDLE;
            end
          end else begin
            // fetch what follows the chain head once the chain is freed
            ram_re    = 1'b1;
            ram_raddr = cur_blk_r;
            state_nxt = ST_RD;
          end
        end else if (too_large) begin
          if (slot_free) begin
            res_load   = 1'b1;
            res_status = STAT_TOO_LARGE;
            state_nxt  = ST_IDLE;
          end
        end else if (!fits) begin
          if (!fh_valid) begin
            if (slot_free) begin
              res_load   = 1'b1;
              res_status = STAT_NO_BLOCKS;
              state_nxt  = ST_IDLE;
            end
          end else begin
            // pop: need the free head's link
            ram_re    = 1'b1;
            ram_raddr = free_head_r[BW-1:0];
            state_nxt = ST_RD;
          end
        end else if (slot_free) begin
          // bump inside the current block
          fill_nxt   = fill_r + FW'(padded);
          res_load   = 1'b1;
          res_status = STAT_OK;
          res_blk    = cur_blk_r;
          res_off    = fill_r;
          state_nxt  = ST_IDLE;
        end
      end

      ST_RD: begin
        if (req_r.cmd == CMD_RELEASE) begin
          // splice the old free list behind the chain tail; the head is reused
          free_head_nxt = rd_link;
          ram_we        = 1'b1;
          ram_waddr     = tail_r;
          ram_wdata     = free_head_r;
          state_nxt     = ST_WR2;
        end else if (slot_free) begin
          // popped block becomes current and links back to the old one
          free_head_nxt = rd_link;
          ram_we        = 1'b1;
          ram_waddr     = free_head_r[BW-1:0];
          ram_wdata     = LW'(cur_blk_r);
          cur_blk_nxt   = free_head_r[BW-1:0];
          fill_nxt      = FW'(padded);
          res_load      = 1'b1;
          res_status    = STAT_OK;
          res_blk       = free_head_r[BW-1:0];
          state_nxt     = ST_IDLE;
        end
      end

      ST_WR2: begin
        if (slot_free) begin
          // fresh chain of the old head alone
          ram_we     = 1'b1;
          ram_waddr  = cur_blk_r;
          ram_wdata  = LINK_NULL;
          tail_nxt   = cur_blk_r;
          fill_nxt   = '0;
          res_load   = 1'b1;
          res_status = STAT_RELEASED;
          res_blk    = cur_blk_r;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (res_load) begin
      out_valid_nxt       = 1'b1;
      out_nxt.status      = res_status;
      out_nxt.block_index = res_blk32[BLKIDX_W-1:0];
      out_nxt.offset      = res_off32[OFFSET_W-1:0];
      out_nxt.address     = res_addr32[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_cnt_r  <= '0;
      free_head_r <= LW'(1);
      cur_blk_r   <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      free_head_r <= free_head_nxt;
      cur_blk_r   <= cur_blk_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  // free list and chain never share their head block
  a_head_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && fh_valid) |-> (free_head_r[BW-1:0] != cur_blk_r))
    else $error("free head equals current block");

  // bump position never runs past the block
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(fill_r) <= CW'(BLOCK_BYTES))
    else $error("fill position beyond block size");

  // the link ram is only touched while a transaction is in work or at init
  a_no_ram_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!ram_we && !ram_re))
    else $error("link ram access while idle");

  // an accepted transaction always goes to decode next
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EXEC))
    else $error("accepted transaction not decoded");

endmodule
`default_nettype wire
